@@ design/ttu_pkg.sv @@
// Shared types and constants for the triangle tangent unit.
`default_nettype none
package ttu_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS = 16;

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_PROD,
		ST_DEN,
		ST_DIV,
		ST_NEXT,
		ST_OUT
	} ctl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic hold0;     // capture corner 0
		logic hold1;     // capture corner 1
		logic start;     // form deltas from corner 2
		logic prod;      // form products
		logic den;       // form denominator and numerator
		logic div_init;  // load divider for current component
		logic div_step;  // one quotient bit
		logic comp_next; // store component, advance
		logic out_load;  // load output register
		logic out_pop;   // output beat taken
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic den_zero;
		logic div_done;
		logic last_comp;
		logic out_full;
	} dp_stat_t;

endpackage
`default_nettype wire

@@ design/ttu_ctrl.sv @@
// Controller state machine for the triangle tangent unit.
`default_nettype none
module ttu_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_fire,
	input  wire logic             in_restart,
	input  wire logic             out_fire,
	input  wire ttu_pkg::dp_stat_t stat,
	output logic                  in_ready,
	output ttu_pkg::ctl_cmd_t     cmd
);
	import ttu_pkg::*;

	ctl_state_t state_q, state_d;
	logic [1:0] count_q, count_d;
	logic [1:0] cur;

	// restart or stray count of three falls back to corner 0
	assign cur = (in_restart || count_q == 2'd3) ? 2'd0 : count_q;

	// next state
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		case (state_q)
			ST_COLLECT: begin
				if (in_fire) begin
					if (cur == 2'd2) begin
						count_d = 2'd0;
						state_d = ST_PROD;
					end else begin
						count_d = cur + 2'd1;
					end
				end
			end
			ST_PROD: state_d = ST_DEN;
			ST_DEN:  state_d = ST_NEXT;
			ST_NEXT: begin
				if (stat.den_zero) state_d = ST_OUT;
				else               state_d = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done) begin
					if (stat.last_comp) state_d = ST_OUT;
					else                state_d = ST_NEXT;
				end
			end
			ST_OUT: if (!stat.out_full || out_fire) state_d = ST_COLLECT;
			default: state_d = ST_COLLECT;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = (state_q == ST_COLLECT);
		cmd.out_pop = out_fire;
		case (state_q)
			ST_COLLECT: begin
				cmd.hold0 = in_fire && cur == 2'd0;
				cmd.hold1 = in_fire && cur == 2'd1;
				cmd.start = in_fire && cur == 2'd2;
			end
			ST_PROD: cmd.prod = 1'b1;
			ST_DEN:  cmd.den = 1'b1;
			ST_NEXT: cmd.div_init = !stat.den_zero;
			ST_DIV: begin
				cmd.div_step  = !stat.div_done;
				cmd.comp_next = stat.div_done;
			end
			ST_OUT: cmd.out_load = !stat.out_full || out_fire;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			count_q <= 2'd0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end
endmodule
`default_nettype wire

@@ design/ttu_dp.sv @@
// Datapath: corner holding, deltas, products, serial divider, output register.
`default_nettype none
module ttu_dp #(
	parameter int COORD_WIDTH = ttu_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ttu_pkg::ctl_cmd_t             cmd,
	input  wire logic signed [COORD_WIDTH-1:0] pos_x,
	input  wire logic signed [COORD_WIDTH-1:0] pos_y,
	input  wire logic signed [COORD_WIDTH-1:0] pos_z,
	input  wire logic signed [COORD_WIDTH-1:0] tex_u,
	input  wire logic signed [COORD_WIDTH-1:0] tex_v,
	output ttu_pkg::dp_stat_t                  stat,
	output logic                               out_valid,
	output logic signed [COORD_WIDTH-1:0]      tangent_x,
	output logic signed [COORD_WIDTH-1:0]      tangent_y,
	output logic signed [COORD_WIDTH-1:0]      tangent_z,
	output logic                               degenerate,
	output logic                               saturated
);
	import ttu_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int DW  = CW + 1;          // delta width
	localparam int PW  = 2 * DW;          // product width
	localparam int NW  = PW + 1;          // sum width
	localparam int UW  = NW + FRAC_BITS;  // shifted numerator magnitude
	localparam int CTW = $clog2(UW + 1);
	localparam logic [UW-1:0] ONE = UW'(1) << FRAC_BITS;
	localparam logic [UW-1:0] MAXP = (UW'(1) << (CW - 1)) - UW'(1);

	logic signed [CW-1:0] p0_q [3];
	logic signed [CW-1:0] p1_q [3];
	logic signed [CW-1:0] u0_q, v0_q, u1_q, v1_q;
	logic signed [DW-1:0] pd_q [3];
	logic signed [DW-1:0] qd_q [3];
	logic signed [DW-1:0] s1_q, t1_q, s2_q, t2_q;
	logic signed [PW-1:0] st_q, ts_q;
	logic signed [PW-1:0] pt_q [3];
	logic signed [PW-1:0] qt_q [3];
	logic signed [NW-1:0] den_q;
	logic signed [NW-1:0] num_q [3];
	logic [UW-1:0] dmag_q, rem_q, quo_q;
	logic [CTW-1:0] cnt_q;
	logic [1:0] comp_q;
	logic neg_q, sat_q;
	logic [CW-1:0] res_q [3];
	logic signed [NW-1:0] cur_num;
	logic [UW-1:0] nmag, rem_sh, lim, mag;
	logic [CW-1:0] comp_val;

	// hold corners and form deltas
	always_ff @(posedge clk) begin
		if (cmd.hold0) begin
			p0_q[0] <= pos_x; p0_q[1] <= pos_y; p0_q[2] <= pos_z;
			u0_q <= tex_u; v0_q <= tex_v;
		end
		if (cmd.hold1) begin
			p1_q[0] <= pos_x; p1_q[1] <= pos_y; p1_q[2] <= pos_z;
			u1_q <= tex_u; v1_q <= tex_v;
		end
		if (cmd.start) begin
			pd_q[0] <= DW'(p1_q[0]) - DW'(p0_q[0]);
			pd_q[1] <= DW'(p1_q[1]) - DW'(p0_q[1]);
			pd_q[2] <= DW'(p1_q[2]) - DW'(p0_q[2]);
			qd_q[0] <= DW'(pos_x) - DW'(p0_q[0]);
			qd_q[1] <= DW'(pos_y) - DW'(p0_q[1]);
			qd_q[2] <= DW'(pos_z) - DW'(p0_q[2]);
			s1_q <= DW'(u1_q) - DW'(u0_q);
			t1_q <= DW'(v1_q) - DW'(v0_q);
			s2_q <= DW'(tex_u) - DW'(u0_q);
			t2_q <= DW'(tex_v) - DW'(v0_q);
		end
		// products in parallel lanes, registered
		if (cmd.prod) begin
			st_q <= PW'(s1_q) * PW'(t2_q);
			ts_q <= PW'(s2_q) * PW'(t1_q);
			for (int k = 0; k < 3; k++) begin
				pt_q[k] <= PW'(pd_q[k]) * PW'(t2_q);
				qt_q[k] <= PW'(qd_q[k]) * PW'(t1_q);
			end
		end
		if (cmd.den) begin
			den_q <= NW'(st_q) - NW'(ts_q);
			for (int k = 0; k < 3; k++) num_q[k] <= NW'(pt_q[k]) - NW'(qt_q[k]);
		end
	end

	// select current numerator
	always_comb begin
		case (comp_q)
			2'd0:    cur_num = num_q[0];
			2'd1:    cur_num = num_q[1];
			default: cur_num = num_q[2];
		endcase
		nmag = cur_num[NW-1] ? UW'(-cur_num) : UW'(cur_num);
		rem_sh = {rem_q[UW-2:0], quo_q[UW-1]};
		lim = neg_q ? MAXP + UW'(1) : MAXP;
		mag = (quo_q > lim) ? lim : quo_q;
		comp_val = neg_q ? CW'(-mag) : CW'(mag);
	end

	// restoring divider, one bit per cycle; quotient shifts in where numerator leaves
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			quo_q  <= nmag << FRAC_BITS;
			rem_q  <= '0;
			dmag_q <= den_q[NW-1] ? UW'(-den_q) : UW'(den_q);
			neg_q  <= cur_num[NW-1] ^ den_q[NW-1];
		end else if (cmd.div_step) begin
			if (rem_sh >= dmag_q) begin
				rem_q <= rem_sh - dmag_q;
				quo_q <= {quo_q[UW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[UW-2:0], 1'b0};
			end
		end
		if (cmd.comp_next) res_q[comp_q] <= comp_val;
	end

	// control registers of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			comp_q <= 2'd0;
			sat_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.den) begin
				comp_q <= 2'd0;
				sat_q <= 1'b0;
			end
			if (cmd.div_init) cnt_q <= CTW'(UW);
			else if (cmd.div_step) cnt_q <= cnt_q - CTW'(1);
			if (cmd.comp_next) begin
				comp_q <= comp_q + 2'd1;
				if (quo_q > lim) sat_q <= 1'b1;
			end
			if (cmd.out_load) out_valid <= 1'b1;
			else if (cmd.out_pop) out_valid <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (den_q == '0) begin
				tangent_x  <= (ONE > MAXP) ? MAXP[CW-1:0] : ONE[CW-1:0];
				tangent_y  <= '0;
				tangent_z  <= '0;
				degenerate <= 1'b1;
				saturated  <= 1'b0;
			end else begin
				tangent_x  <= res_q[0];
				tangent_y  <= res_q[1];
				tangent_z  <= res_q[2];
				degenerate <= 1'b0;
				saturated  <= sat_q;
			end
		end
	end

	assign stat.den_zero  = (den_q == '0);
	assign stat.div_done  = (cnt_q == '0);
	assign stat.last_comp = (comp_q == 2'd2);
	assign stat.out_full  = out_valid;
endmodule
`default_nettype wire

@@ design/triangle_tangent_unit.sv @@
// Top level of the triangle tangent unit.
// channel | dir | payload
// s_axis  | in  | restart in tuser; pos_x,pos_y,pos_z,tex_u,tex_v in tdata
// m_axis  | out | tangent_x,y,z in tdata; degenerate,saturated in tuser
// Corners 0 and 1 are held in registers. Corner 2 closes the input while the unit works:
// products, denominator, then per component a divider load, 2*COORD_WIDTH+19
// one-bit restoring steps and a store, then the output load. A zero denominator
// skips the divider.
// Reset is asynchronous, active low. The result sits in an output register; a
// stalled m_axis holds only the hand-off of the next result, input stays closed until it is stored.
`default_nettype none
module triangle_tangent_unit #(
	parameter int COORD_WIDTH = ttu_pkg::COORD_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic      s_axis_tready,
	// pos_x, pos_y, pos_z, tex_u, tex_v from bit 0 up
	input  wire logic [((5*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	// restart
	input  wire logic s_axis_tuser,
	output logic      m_axis_tvalid,
	input  wire logic m_axis_tready,
	// tangent_x, tangent_y, tangent_z from bit 0 up
	output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// degenerate, saturated from bit 0 up
	output logic [1:0] m_axis_tuser
);
	import ttu_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int OWB = ((3*CW+7)/8)*8;

	ctl_cmd_t cmd;
	dp_stat_t stat;
	logic in_fire, out_fire;
	logic signed [CW-1:0] tx, ty, tz;
	logic degen, sat;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	ttu_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .in_restart(s_axis_tuser), .out_fire,
		.stat, .in_ready(s_axis_tready), .cmd
	);

	ttu_dp #(.COORD_WIDTH(CW)) u_dp (
		.clk, .arst_n, .cmd,
		.pos_x(s_axis_tdata[CW-1:0]),
		.pos_y(s_axis_tdata[2*CW-1:CW]),
		.pos_z(s_axis_tdata[3*CW-1:2*CW]),
		.tex_u(s_axis_tdata[4*CW-1:3*CW]),
		.tex_v(s_axis_tdata[5*CW-1:4*CW]),
		.stat, .out_valid(m_axis_tvalid),
		.tangent_x(tx), .tangent_y(ty), .tangent_z(tz),
		.degenerate(degen), .saturated(sat)
	);

	// pack result beat
	assign m_axis_tdata = OWB'({tz, ty, tx});
	assign m_axis_tuser = {sat, degen};
endmodule
`default_nettype wire
